@@ hdl/assert_macros.svh @@
// Assertion macros shared by the span generator modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, prop)
`endif
`endif

@@ hdl/mcsg_pkg.sv @@
// Types and constants of the midpoint circle span generator.
package mcsg_pkg;

	localparam int COORD_BITS  = 16;
	localparam int RADIUS_BITS = 12;
	localparam int ROW_W       = RADIUS_BITS + 1;
	localparam int SPAN_W      = COORD_BITS + 2;
	localparam int DEC_W       = 20;
	localparam int PIX_W       = 12;
	localparam int LEN_W       = 13;
	localparam int COLOR_W     = 32;
	localparam int OFFSET_W    = 32;
	localparam int PITCH_W     = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int NSPANS      = 4;
	localparam int SPAN_IDX_W  = 2;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;
	localparam int IN_TDATA_W  = 80;
	localparam int OUT_TDATA_W = 104;

	localparam logic [LEN_W-1:0] FRAME_MAX = LEN_W'(4096);

	typedef enum logic {
		CMD_START   = 1'b0,
		CMD_ADVANCE = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_ROW_PITCH    = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [LEN_W-1:0]   width;
		logic [LEN_W-1:0]   height;
		logic [PITCH_W-1:0] pitch;
	} cfg_t;

	typedef struct packed {
		logic                         idle;
		logic                         done;
		logic signed [COORD_BITS-1:0] cx;
		logic signed [COORD_BITS-1:0] cy;
		logic [ROW_W-1:0]             col;
		logic [ROW_W-1:0]             row;
		logic [COLOR_W-1:0]           color;
	} step_entry_t;

	typedef struct packed {
		logic                span_valid;
		logic [PIX_W-1:0]    x;
		logic [PIX_W-1:0]    y;
		logic [LEN_W-1:0]    len;
		logic [OFFSET_W-1:0] offset;
		logic [COLOR_W-1:0]  color;
		logic                last;
		logic                done;
	} result_t;

endpackage

@@ hdl/mcsg_fifo.sv @@
// Short queue of stepped circle positions between front and back end.
`include "assert_macros.svh"

module mcsg_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  mcsg_pkg::step_entry_t push_entry,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output mcsg_pkg::step_entry_t head_entry
);

	mcsg_pkg::step_entry_t             mem_q [mcsg_pkg::FIFO_DEPTH];
	logic [mcsg_pkg::FIFO_AW-1:0]      wr_ptr_q;
	logic [mcsg_pkg::FIFO_AW-1:0]      rd_ptr_q;
	logic [mcsg_pkg::FIFO_AW:0]        count_q;
	logic                              do_push;
	logic                              do_pop;

	assign full       = (count_q == (mcsg_pkg::FIFO_AW+1)'(mcsg_pkg::FIFO_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_fifo_count_range, clk, arst_n,
		count_q > (mcsg_pkg::FIFO_AW+1)'(mcsg_pkg::FIFO_DEPTH))

endmodule

@@ hdl/mcsg_front.sv @@
// Command front end: holds the midpoint stepper and queues one entry per advance.
`include "assert_macros.svh"

module mcsg_front (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  mcsg_pkg::cmd_t                        cmd,
	input  logic signed [mcsg_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [mcsg_pkg::COORD_BITS-1:0] center_y,
	input  logic [mcsg_pkg::RADIUS_BITS-1:0]      radius,
	input  logic [mcsg_pkg::COLOR_W-1:0]          fill_color,
	output logic                                  push,
	output mcsg_pkg::step_entry_t                 push_entry,
	input  logic                                  full
);

	localparam int RW = mcsg_pkg::ROW_W;
	localparam int DW = mcsg_pkg::DEC_W;

	logic signed [mcsg_pkg::COORD_BITS-1:0] held_center_x_q;
	logic signed [mcsg_pkg::COORD_BITS-1:0] held_center_y_q;
	logic [mcsg_pkg::COLOR_W-1:0]           held_color_q;
	logic [RW-1:0]                          step_col_q;
	logic [RW-1:0]                          step_row_q;
	logic signed [DW-1:0]                   decision_q;
	logic                                   active_q;

	logic                  accept;
	logic                  d_pos;
	logic signed [RW:0]    x_nx;
	logic signed [RW:0]    y_nx;
	logic signed [RW:0]    diff;
	logic signed [DW-1:0]  d_inc;
	logic signed [DW-1:0]  d_init;
	logic                  done_nx;

	assign in_ready = !full;
	assign accept   = in_valid && !full;
	assign push     = accept && (cmd == mcsg_pkg::CMD_ADVANCE);

	always_comb begin
		d_pos = !decision_q[DW-1] && (decision_q != '0);
		x_nx  = $signed({1'b0, step_col_q}) + (RW+1)'(1);
		y_nx  = d_pos ? $signed({1'b0, step_row_q}) - (RW+1)'(1) : $signed({1'b0, step_row_q});
		diff  = x_nx - y_nx;
		if (d_pos) begin
			d_inc = $signed({{(DW-RW-3){diff[RW]}}, diff, 2'b00}) + DW'(10);
		end else begin
			d_inc = $signed({{(DW-RW-3){x_nx[RW]}}, x_nx, 2'b00}) + DW'(6);
		end
		done_nx = (y_nx < x_nx);
		d_init  = DW'(3) - $signed({{(DW-mcsg_pkg::RADIUS_BITS-1){1'b0}}, radius, 1'b0});
	end

	always_comb begin
		push_entry.idle  = !active_q;
		push_entry.done  = active_q ? done_nx : 1'b1;
		push_entry.cx    = held_center_x_q;
		push_entry.cy    = held_center_y_q;
		push_entry.col   = step_col_q;
		push_entry.row   = step_row_q;
		push_entry.color = held_color_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_center_x_q <= '0;
			held_center_y_q <= '0;
			held_color_q    <= '0;
			step_col_q      <= '0;
			step_row_q      <= '0;
			decision_q      <= '0;
			active_q        <= 1'b0;
		end else if (accept) begin
			if (cmd == mcsg_pkg::CMD_START) begin
				held_center_x_q <= center_x;
				held_center_y_q <= center_y;
				held_color_q    <= fill_color;
				step_col_q      <= '0;
				step_row_q      <= RW'(radius);
				decision_q      <= d_init;
				active_q        <= 1'b1;
			end else if (active_q) begin
				step_col_q <= x_nx[RW-1:0];
				step_row_q <= y_nx[RW-1:0];
				decision_q <= decision_q + d_inc;
				active_q   <= !done_nx;
			end
		end
	end

	`ASSERT_CLK(a_active_row_ge_col, clk, arst_n, !active_q || (step_row_q >= step_col_q))

endmodule

@@ hdl/mcsg_back.sv @@
// Span back end: clips a step's four spans; emits kept ones (or one null result) one per cycle unless stalled.
`include "assert_macros.svh"

module mcsg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mcsg_pkg::cfg_t        cfg,
	input  logic                  head_valid,
	input  mcsg_pkg::step_entry_t head_entry,
	output logic                  pop,
	output logic                  res_valid,
	input  logic                  res_ready,
	output mcsg_pkg::result_t     res
);

	localparam int SW = mcsg_pkg::SPAN_W;
	localparam int NS = mcsg_pkg::NSPANS;

	logic signed [SW-1:0] xs [NS];
	logic signed [SW-1:0] ys [NS];
	logic signed [SW-1:0] ln [NS];
	logic signed [SW-1:0] x2 [NS];
	logic signed [SW-1:0] x1c [NS];
	logic signed [SW-1:0] x2c [NS];
	logic signed [SW-1:0] span_len [NS];
	logic signed [SW-1:0] cx_e;
	logic signed [SW-1:0] cy_e;
	logic signed [SW-1:0] col_e;
	logic signed [SW-1:0] row_e;
	logic signed [SW-1:0] w_e;
	logic signed [SW-1:0] h_e;
	logic [NS-1:0]        keep;

	logic                               work_valid_s1;
	logic [NS-1:0]                      rem_s1;
	logic                               done_s1;
	logic [mcsg_pkg::COLOR_W-1:0]       color_s1;
	logic [mcsg_pkg::PIX_W-1:0]         sx_s1 [NS];
	logic [mcsg_pkg::PIX_W-1:0]         sy_s1 [NS];
	logic [mcsg_pkg::LEN_W-1:0]         slen_s1 [NS];

	logic                               out_valid_q;
	mcsg_pkg::result_t                  out_q;

	logic                               out_ok;
	logic                               emit;
	logic                               last;
	logic                               null_res;
	logic [mcsg_pkg::SPAN_IDX_W-1:0]    k;
	logic [NS-1:0]                      rem_next;
	logic [2*mcsg_pkg::PITCH_W-1:0]     prod;
	logic [mcsg_pkg::OFFSET_W-1:0]      offset;

	always_comb begin
		cx_e  = $signed({{(SW-mcsg_pkg::COORD_BITS){head_entry.cx[mcsg_pkg::COORD_BITS-1]}},
			head_entry.cx});
		cy_e  = $signed({{(SW-mcsg_pkg::COORD_BITS){head_entry.cy[mcsg_pkg::COORD_BITS-1]}},
			head_entry.cy});
		col_e = $signed({{(SW-mcsg_pkg::ROW_W){1'b0}}, head_entry.col});
		row_e = $signed({{(SW-mcsg_pkg::ROW_W){1'b0}}, head_entry.row});
		w_e   = $signed({{(SW-mcsg_pkg::LEN_W){1'b0}}, cfg.width});
		h_e   = $signed({{(SW-mcsg_pkg::LEN_W){1'b0}}, cfg.height});
		xs[0] = cx_e - row_e;  ys[0] = cy_e - col_e;  ln[0] = row_e + row_e + SW'(1);
		xs[1] = cx_e - row_e;  ys[1] = cy_e + col_e;  ln[1] = row_e + row_e + SW'(1);
		xs[2] = cx_e - col_e;  ys[2] = cy_e - row_e;  ln[2] = col_e + col_e + SW'(1);
		xs[3] = cx_e - col_e;  ys[3] = cy_e + row_e;  ln[3] = col_e + col_e + SW'(1);
		for (int i = 0; i < NS; i++) begin
			x2[i]       = xs[i] + ln[i];
			x1c[i]      = xs[i][SW-1] ? '0 : xs[i];
			x2c[i]      = (x2[i] > w_e) ? w_e : x2[i];
			span_len[i] = x2c[i] - x1c[i];
			keep[i] = !head_entry.idle && !ys[i][SW-1] && (ys[i] < h_e) && (x1c[i] < x2c[i]);
		end
	end

	assign out_ok   = !out_valid_q || res_ready;
	assign emit     = work_valid_s1 && out_ok;
	assign rem_next = rem_s1 & (rem_s1 - NS'(1));
	assign last     = (rem_next == '0);
	assign null_res = (rem_s1 == '0);
	assign pop      = head_valid && (!work_valid_s1 || (emit && last));

	always_comb begin
		if (rem_s1[0]) begin
			k = mcsg_pkg::SPAN_IDX_W'(0);
		end else if (rem_s1[1]) begin
			k = mcsg_pkg::SPAN_IDX_W'(1);
		end else if (rem_s1[2]) begin
			k = mcsg_pkg::SPAN_IDX_W'(2);
		end else begin
			k = mcsg_pkg::SPAN_IDX_W'(3);
		end
		prod   = {{(mcsg_pkg::PITCH_W-mcsg_pkg::PIX_W){1'b0}}, sy_s1[k]} * cfg.pitch;
		offset = prod + {{(mcsg_pkg::OFFSET_W-mcsg_pkg::PIX_W-2){1'b0}}, sx_s1[k], 2'b00};
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			done_s1  <= head_entry.done;
			color_s1 <= head_entry.color;
			for (int i = 0; i < NS; i++) begin
				sx_s1[i]   <= x1c[i][mcsg_pkg::PIX_W-1:0];
				sy_s1[i]   <= ys[i][mcsg_pkg::PIX_W-1:0];
				slen_s1[i] <= span_len[i][mcsg_pkg::LEN_W-1:0];
			end
		end
		if (emit) begin
			out_q.span_valid <= !null_res;
			out_q.x          <= null_res ? '0 : sx_s1[k];
			out_q.y          <= null_res ? '0 : sy_s1[k];
			out_q.len        <= null_res ? '0 : slen_s1[k];
			out_q.offset     <= null_res ? '0 : offset;
			out_q.color      <= null_res ? '0 : color_s1;
			out_q.last       <= last;
			out_q.done       <= last && done_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_valid_s1 <= 1'b0;
			rem_s1        <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				work_valid_s1 <= 1'b1;
				rem_s1        <= keep;
			end else if (emit && last) begin
				work_valid_s1 <= 1'b0;
				rem_s1        <= '0;
			end else if (emit) begin
				rem_s1 <= rem_next;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

	`ASSERT_CLK(a_null_is_last, clk, arst_n, !(out_valid_q && !out_q.span_valid) || out_q.last)
	`ASSERT_CLK(a_kept_not_empty, clk, arst_n,
		!(out_valid_q && out_q.span_valid) || (out_q.len != '0))

endmodule

@@ hdl/midpoint_circle_span_generator.sv @@
// Top level of the filled-circle span generator: ports, config registers, front and back.
//
//   channel   direction  payload
//   s_axis    in         tuser: command; tdata: center_x, center_y, radius, fill_color
//   cfg       in         cfg_index selects register, cfg_data holds value
//   m_axis    out        tuser: span_valid, circle_done; tlast: step_last;
//                        tdata: span_x, span_y, span_length, byte_offset, span_color
//
// A command transfer is accepted when the four-entry step queue has room.
// An advance occupies the back end for one transfer per kept span (one null transfer if none
// is kept), so a fully visible step makes four transfers through the single span output port.
// The offset multiply sits between the span registers and the output register.
// Reset is asynchronous and needs no clearing pass; a stalled m_axis holds the back end.
`include "assert_macros.svh"

module midpoint_circle_span_generator (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [15:0] center_x, [31:16] center_y, [43:32] radius, [75:44] fill_color
	input  logic [mcsg_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// [0] command
	input  logic [0:0]                           s_axis_tuser,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [1:0]                           cfg_index,
	input  logic [mcsg_pkg::CFG_DATA_W-1:0]      cfg_data,
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [11:0] span_x, [23:12] span_y, [36:24] span_length, [68:37] byte_offset,
	// [100:69] span_color
	output logic [mcsg_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
	// [0] span_valid, [1] circle_done
	output logic [1:0]                           m_axis_tuser,
	output logic                                 m_axis_tlast
);

	mcsg_pkg::cfg_t           cfg_q;
	logic [mcsg_pkg::LEN_W-1:0] frame_val;
	logic [mcsg_pkg::LEN_W-1:0] frame_sat;
	logic                     push;
	mcsg_pkg::step_entry_t    push_entry;
	logic                     full;
	logic                     pop;
	logic                     head_valid;
	mcsg_pkg::step_entry_t    head_entry;
	mcsg_pkg::result_t        res;

	assign cfg_ready = 1'b1;
	assign frame_val = cfg_data[mcsg_pkg::LEN_W-1:0];
	assign frame_sat = (frame_val > mcsg_pkg::FRAME_MAX) ? mcsg_pkg::FRAME_MAX : frame_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			case (mcsg_pkg::cfg_reg_t'(cfg_index))
				mcsg_pkg::REG_FRAME_WIDTH:  cfg_q.width  <= frame_sat;
				mcsg_pkg::REG_FRAME_HEIGHT: cfg_q.height <= frame_sat;
				mcsg_pkg::REG_ROW_PITCH:    cfg_q.pitch  <= cfg_data[mcsg_pkg::PITCH_W-1:0];
				default:                    cfg_q        <= cfg_q;
			endcase
		end
	end

	mcsg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.in_ready   (s_axis_tready),
		.cmd        (mcsg_pkg::cmd_t'(s_axis_tuser[0])),
		.center_x   ($signed(s_axis_tdata[15:0])),
		.center_y   ($signed(s_axis_tdata[31:16])),
		.radius     (s_axis_tdata[43:32]),
		.fill_color (s_axis_tdata[75:44]),
		.push       (push),
		.push_entry (push_entry),
		.full       (full)
	);

	mcsg_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	mcsg_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	assign m_axis_tdata = {3'b000, res.color, res.offset, res.len, res.y, res.x};
	assign m_axis_tuser = {res.done, res.span_valid};
	assign m_axis_tlast = res.last;

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the midpoint circle span generator.
`timescale 1ns / 100ps

class span_ledger;
	longint frame_w;
	longint frame_h;
	longint pitch;
	longint hold_cx;
	longint hold_cy;
	logic [31:0] hold_color;
	longint col;
	longint row;
	longint dec;
	bit running;
	mcsg_pkg::result_t pending_spans[$];
	int failures;

	function new();
		frame_w = 0;
		frame_h = 0;
		pitch = 0;
		hold_cx = 0;
		hold_cy = 0;
		hold_color = '0;
		col = 0;
		row = 0;
		dec = 0;
		running = 1'b0;
		failures = 0;
	endfunction

	function int pending();
		return pending_spans.size();
	endfunction

	function void set_register(mcsg_pkg::cfg_reg_t idx, logic [15:0] value);
		case (idx)
			mcsg_pkg::REG_FRAME_WIDTH: frame_w = longint'(value[12:0]);
			mcsg_pkg::REG_FRAME_HEIGHT: frame_h = longint'(value[12:0]);
			mcsg_pkg::REG_ROW_PITCH: pitch = longint'(value);
			default: ;
		endcase
	endfunction

	function bit clip_span(longint xs, longint ys, longint len, output mcsg_pkg::result_t s);
		longint w;
		longint h;
		longint x1;
		longint x2;
		s = '0;
		w = (frame_w > 4096) ? 4096 : frame_w;
		h = (frame_h > 4096) ? 4096 : frame_h;
		x1 = xs;
		x2 = xs + len;
		if (ys < 0 || ys >= h)
			return 1'b0;
		if (x1 < 0)
			x1 = 0;
		if (x2 > w)
			x2 = w;
		if (x1 >= x2)
			return 1'b0;
		s.span_valid = 1'b1;
		s.x = x1[11:0];
		s.y = ys[11:0];
		s.len = 13'(x2 - x1);
		s.offset = 32'(ys * pitch + x1 * 4);
		s.color = hold_color;
		return 1'b1;
	endfunction

	function void take_command(mcsg_pkg::cmd_t cmd, logic signed [15:0] cx,
			logic signed [15:0] cy, logic [11:0] r, logic [31:0] color);
		mcsg_pkg::result_t outs[4];
		mcsg_pkg::result_t s;
		longint xs[4];
		longint ys[4];
		longint ln[4];
		int n;
		bit fin;
		if (cmd == mcsg_pkg::CMD_START) begin
			hold_cx = longint'(cx);
			hold_cy = longint'(cy);
			hold_color = color;
			col = 0;
			row = longint'(r);
			dec = 3 - 2 * row;
			running = 1'b1;
			return;
		end
		if (!running) begin
			s = '0;
			s.last = 1'b1;
			s.done = 1'b1;
			pending_spans.push_back(s);
			return;
		end
		xs[0] = hold_cx - row;
		ys[0] = hold_cy - col;
		ln[0] = 2 * row + 1;
		xs[1] = hold_cx - row;
		ys[1] = hold_cy + col;
		ln[1] = 2 * row + 1;
		xs[2] = hold_cx - col;
		ys[2] = hold_cy - row;
		ln[2] = 2 * col + 1;
		xs[3] = hold_cx - col;
		ys[3] = hold_cy + row;
		ln[3] = 2 * col + 1;
		n = 0;
		for (int k = 0; k < 4; k++) begin
			if (clip_span(xs[k], ys[k], ln[k], s)) begin
				outs[n] = s;
				n++;
			end
		end
		col++;
		if (dec > 0) begin
			row--;
			dec += 4 * (col - row) + 10;
		end else begin
			dec += 4 * col + 6;
		end
		fin = row < col;
		if (fin)
			running = 1'b0;
		if (n == 0) begin
			outs[0] = '0;
			n = 1;
		end
		outs[n-1].last = 1'b1;
		outs[n-1].done = fin;
		for (int k = 0; k < n; k++)
			pending_spans.push_back(outs[k]);
	endfunction

	function string describe(mcsg_pkg::result_t s);
		return $sformatf("valid=%0d x=%0d y=%0d len=%0d offset=%h color=%h last=%0d done=%0d",
			s.span_valid, s.x, s.y, s.len, s.offset, s.color, s.last, s.done);
	endfunction

	function void match_span(mcsg_pkg::result_t got);
		mcsg_pkg::result_t want;
		if (pending_spans.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("unexpected span transfer: %s", describe(got));
			return;
		end
		want = pending_spans.pop_front();
		if (got.span_valid !== want.span_valid || got.x !== want.x || got.y !== want.y
				|| got.len !== want.len || got.offset !== want.offset
				|| got.color !== want.color || got.last !== want.last
				|| got.done !== want.done) begin
			failures++;
			if (failures <= 10) begin
				$display("span mismatch at %0t", $time);
				$display("  expected %s", describe(want));
				$display("  actual   %s", describe(got));
			end
		end
	endfunction
endclass

module testbench;
	localparam int LIMIT = 200000;
	localparam int SETTLE_CYCLES = 16;
	localparam int STALL_CYCLES = 150;
	localparam int PHASE_ITEMS = 28;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [mcsg_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [0:0] s_axis_tuser = '0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [mcsg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [mcsg_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0] m_axis_tuser;
	logic m_axis_tlast;

	span_ledger ledger = new();
	bit quiet = 1'b0;
	bit stall_req = 1'b0;
	int items_sent = 0;
	int cycle_count = 0;

	midpoint_circle_span_generator dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		mcsg_pkg::result_t got;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.span_valid = m_axis_tuser[0];
				got.done = m_axis_tuser[1];
				got.last = m_axis_tlast;
				got.x = m_axis_tdata[11:0];
				got.y = m_axis_tdata[23:12];
				got.len = m_axis_tdata[36:24];
				got.offset = m_axis_tdata[68:37];
				got.color = m_axis_tdata[100:69];
				ledger.match_span(got);
			end
			if (s_axis_tvalid && s_axis_tready)
				ledger.take_command(mcsg_pkg::cmd_t'(s_axis_tuser[0]), s_axis_tdata[15:0],
					s_axis_tdata[31:16], s_axis_tdata[43:32], s_axis_tdata[75:44]);
			if (cfg_valid && cfg_ready)
				ledger.set_register(mcsg_pkg::cfg_reg_t'(cfg_index), cfg_data);
		end
	end

	// hold off the span output on request, otherwise accept at random
	initial begin
		forever begin
			@(posedge clk);
			if (stall_req) begin
				m_axis_tready <= 1'b0;
				repeat (STALL_CYCLES) @(posedge clk);
				stall_req = 1'b0;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(99) >= 16);
			end
		end
	end

	task automatic send_command(mcsg_pkg::cmd_t cmd, logic [15:0] cx, logic [15:0] cy,
			logic [11:0] r, logic [31:0] color);
		while (!quiet && $urandom_range(99) < 16) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'b0, color, r, cy, cx};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic start_circle(logic [15:0] cx, logic [15:0] cy, logic [11:0] r,
			logic [31:0] color);
		send_command(mcsg_pkg::CMD_START, cx, cy, r, color);
	endtask

	task automatic advance(int count);
		repeat (count)
			send_command(mcsg_pkg::CMD_ADVANCE, 16'($urandom), 16'($urandom),
				12'($urandom), $urandom);
	endtask

	task automatic drain_spans();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (ledger.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(mcsg_pkg::cfg_reg_t idx, logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
	endtask

	task automatic set_frame(logic [15:0] w, logic [15:0] h, logic [15:0] p);
		drain_spans();
		write_reg(mcsg_pkg::REG_FRAME_WIDTH, w);
		write_reg(mcsg_pkg::REG_FRAME_HEIGHT, h);
		write_reg(mcsg_pkg::REG_ROW_PITCH, p);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_circle();
		int w;
		int h;
		int r;
		int full;
		int sel;
		logic [15:0] cx;
		logic [15:0] cy;
		w = (ledger.frame_w > 4096) ? 4096 : int'(ledger.frame_w);
		h = (ledger.frame_h > 4096) ? 4096 : int'(ledger.frame_h);
		if ($urandom_range(9) < 7) begin
			cx = 16'($urandom_range(w + 40) - 20);
			cy = 16'($urandom_range(h + 40) - 20);
		end else begin
			cx = 16'($urandom);
			cy = 16'($urandom);
		end
		sel = $urandom_range(99);
		if (sel < 80)
			r = $urandom_range(24);
		else if (sel < 95)
			r = $urandom_range(300, 25);
		else
			r = $urandom_range(4095);
		// stray advance outside a well-formed sequence
		if ($urandom_range(9) == 0)
			advance(1);
		start_circle(cx, cy, 12'(r), $urandom);
		if (r <= 40) begin
			full = (r * 71) / 100 + 2;
			if ($urandom_range(99) < 85)
				advance(full + $urandom_range(1));
			else
				advance($urandom_range(full));
		end else begin
			advance($urandom_range(8, 1));
		end
	endtask

	task automatic random_phase();
		int first;
		first = items_sent;
		while (items_sent - first < PHASE_ITEMS)
			random_circle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_frame(16'd64, 16'd48, 16'd256);
		advance(1);
		start_circle(16'd10, 16'd10, 12'd0, 32'hFFFF_FFFF);
		advance(2);
		start_circle(16'd0, 16'd0, 12'd5, 32'h0000_0000);
		advance(5);
		start_circle(16'h8000, 16'h7FFF, 12'd4095, 32'h1234_5678);
		advance(2);
		start_circle(16'h7FFF, 16'h8000, 12'd4095, 32'hDEAD_BEEF);
		advance(1);
		start_circle(16'd63, 16'd47, 12'd3, 32'h5A5A_5A5A);
		advance(1);
		start_circle(16'd20, 16'd20, 12'd10, 32'hA5A5_A5A5);
		advance(3);

		fork
			random_phase();
			begin
				repeat (30) @(posedge clk);
				stall_req = 1'b1;
			end
		join

		set_frame(16'hFFFF, 16'hFFFF, 16'hFFFF);
		random_circle();
		random_circle();
		drain_spans();
		random_phase();

		set_frame(16'd0, 16'd0, 16'h8000);
		random_phase();

		set_frame(16'd4096, 16'd4096, 16'd0);
		quiet = 1'b1;
		random_phase();
		quiet = 1'b0;

		set_frame(16'($urandom_range(300, 1)), 16'($urandom_range(300, 1)), 16'($urandom));
		random_phase();

		drain_spans();
		if (ledger.failures == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
